// ===== hw/rtl/spq_pkg.sv =====
// Package: request/result types and fixed constants of the stable priority queue.
`default_nettype none

package spq_pkg;

    localparam int URG_W     = 3;
    localparam int OUT_TAG_W = 16;
    localparam int OCC_W     = 5;

    localparam logic [URG_W-1:0] URG_MIN = 3'd1;
    localparam logic [URG_W-1:0] URG_MAX = 3'd5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SERVE  = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [OUT_TAG_W-1:0] entry_tag;
        logic [URG_W-1:0]     urgency;
    } req_t;

    typedef struct packed {
        logic                 served_valid;
        logic [OUT_TAG_W-1:0] served_tag;
        logic [URG_W-1:0]     served_urgency;
        logic                 empty_serve;
        logic                 insert_dropped;
        logic                 head_valid;
        logic [OUT_TAG_W-1:0] head_tag;
        logic [URG_W-1:0]     head_urgency;
        logic [OCC_W-1:0]     occupancy;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ram.sv =====
// Simple dual-port entry memory: one write port, one registered read port.
`default_nettype none

module spq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 19
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stable_priority_queue_top.sv =====
// Top level: stable priority queue kept sorted in one entry memory.
// A dropped insert, an empty serve, an insert into an empty queue or a serve of
// the last entry goes straight to S_FIN; any other insert walks S_INS, moving
// entries back, and S_INS_LAST if it reaches the front; any other serve walks
// S_SRV. One item at a time; one write and one registered read memory port move
// one entry a cycle. Reset clears the count; memory contents stay undefined.
`default_nettype none

module stable_priority_queue_top #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire spq_pkg::req_t req,
    output logic               busy,
    output logic               done,
    output spq_pkg::rsp_t      rsp
);

    import spq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TAG_BITS + URG_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS      = 5'b00010,
        S_INS_LAST = 5'b00100,
        S_SRV      = 5'b01000,
        S_FIN      = 5'b10000
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         count_reg;
    logic [IW-1:0]         idx_reg;
    logic [TAG_BITS-1:0]   new_tag_reg;
    logic [URG_W-1:0]      new_urg_reg;
    logic [TAG_BITS-1:0]   head_tag_reg;
    logic [URG_W-1:0]      head_urg_reg;
    logic                  sv_reg;
    logic [TAG_BITS-1:0]   st_reg;
    logic [URG_W-1:0]      su_reg;
    logic                  empty_reg;
    logic                  drop_reg;
    logic                  done_reg;
    rsp_t                  rsp_reg;

    logic                  accept;
    logic [TAG_BITS-1:0]   tag_in;
    logic [URG_W-1:0]      urg_in;
    logic [IW-1:0]         last_idx;
    logic                  full;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [URG_W-1:0]      rd_urg;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign tag_in   = TAG_BITS'(req.entry_tag);
    assign urg_in   = (req.urgency < URG_MIN) ? URG_MIN :
                      (req.urgency > URG_MAX) ? URG_MAX : req.urgency;
    assign last_idx = IW'(count_reg - 1'b1);
    assign full     = (count_reg == CW'(DEPTH));
    assign rd_tag   = ram_rdata[EW-1:URG_W];
    assign rd_urg   = ram_rdata[URG_W-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {new_tag_reg, new_urg_reg};
        ram_raddr = last_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.req_type == REQ_SERVE)
                begin
                    ram_raddr = IW'(1);
                end
                else if (accept && (count_reg == '0))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {tag_in, urg_in};
                end
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(idx_reg + 1'b1);
                ram_raddr = IW'(idx_reg - 1'b1);
                if (rd_urg > new_urg_reg)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            S_INS_LAST:
            begin
                ram_we = 1'b1;
            end
            S_SRV:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(idx_reg - 1'b1);
                ram_wdata = ram_rdata;
                ram_raddr = IW'(idx_reg + 1'b1);
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    spq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_FIN;
                        if (req.req_type == REQ_INSERT)
                        begin
                            if (full)
                            begin
                                state_reg <= S_FIN;
                            end
                            else if (count_reg == '0)
                            begin
                                count_reg <= CW'(1);
                            end
                            else
                            begin
                                state_reg <= S_INS;
                            end
                        end
                        else if (count_reg == CW'(1))
                        begin
                            count_reg <= '0;
                        end
                        else if (count_reg != '0)
                        begin
                            state_reg <= S_SRV;
                        end
                    end
                end
                S_INS:
                begin
                    if (rd_urg > new_urg_reg)
                    begin
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_INS_LAST;
                        end
                    end
                    else
                    begin
                        count_reg <= CW'(count_reg + 1'b1);
                        state_reg <= S_FIN;
                    end
                end
                S_INS_LAST:
                begin
                    count_reg <= CW'(count_reg + 1'b1);
                    state_reg <= S_FIN;
                end
                S_SRV:
                begin
                    if (idx_reg == last_idx)
                    begin
                        count_reg <= CW'(count_reg - 1'b1);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_tag_reg <= tag_in;
                    new_urg_reg <= urg_in;
                    sv_reg      <= 1'b0;
                    st_reg      <= '0;
                    su_reg      <= '0;
                    empty_reg   <= 1'b0;
                    drop_reg    <= 1'b0;
                    if (req.req_type == REQ_INSERT)
                    begin
                        idx_reg <= last_idx;
                        if (full)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            head_tag_reg <= tag_in;
                            head_urg_reg <= urg_in;
                        end
                    end
                    else
                    begin
                        idx_reg <= IW'(1);
                        if (count_reg == '0)
                        begin
                            empty_reg <= 1'b1;
                        end
                        else
                        begin
                            sv_reg <= 1'b1;
                            st_reg <= head_tag_reg;
                            su_reg <= head_urg_reg;
                        end
                    end
                end
            end
            S_INS:
            begin
                if (rd_urg > new_urg_reg)
                begin
                    idx_reg <= IW'(idx_reg - 1'b1);
                end
            end
            S_INS_LAST:
            begin
                head_tag_reg <= new_tag_reg;
                head_urg_reg <= new_urg_reg;
            end
            S_SRV:
            begin
                if (idx_reg == IW'(1))
                begin
                    head_tag_reg <= rd_tag;
                    head_urg_reg <= rd_urg;
                end
                idx_reg <= IW'(idx_reg + 1'b1);
            end
            S_FIN:
            begin
                rsp_reg.served_valid   <= sv_reg;
                rsp_reg.served_tag     <= OUT_TAG_W'(st_reg);
                rsp_reg.served_urgency <= su_reg;
                rsp_reg.empty_serve    <= empty_reg;
                rsp_reg.insert_dropped <= drop_reg;
                rsp_reg.head_valid     <= (count_reg != '0);
                rsp_reg.head_tag       <= (count_reg != '0) ? OUT_TAG_W'(head_tag_reg) : '0;
                rsp_reg.head_urgency   <= (count_reg != '0) ? head_urg_reg : '0;
                rsp_reg.occupancy      <= OCC_W'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/stable_priority_queue_top_tb.sv =====
// Testbench: random and directed requests checked against a cycle-free queue predictor.
`timescale 1ns / 100ps

module stable_priority_queue_top_tb;

    import spq_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int RANDOM_ITEMS   = 650;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PCT       = 7;
    localparam int QUIET_FROM     = 250;
    localparam int QUIET_TO       = 400;

    typedef struct {
        req_t r;
        bit   drain;
    } backlog_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    backlog_item_t       req_backlog[$];
    rsp_t                rsp_due[$];
    logic [OUT_TAG_W-1:0] model_tag[QDEPTH];
    logic [URG_W-1:0]     model_urg[QDEPTH];
    int                   model_count = 0;
    int                   mismatch_cnt = 0;
    int                   n_taken = 0;
    int                   stall_cycles = 0;

    stable_priority_queue_top #(
        .DEPTH    (QDEPTH),
        .TAG_BITS (16)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    function automatic rsp_t queue_model_step(req_t r);
        rsp_t             o;
        logic [URG_W-1:0] u;
        int               pos;
        o = '0;
        if (r.req_type == REQ_INSERT) begin
            u = r.urgency;
            if (u < URG_MIN)
                u = URG_MIN;
            else if (u > URG_MAX)
                u = URG_MAX;
            if (model_count >= QDEPTH) begin
                o.insert_dropped = 1'b1;
            end
            else begin
                pos = 0;
                while (pos < model_count && model_urg[pos] <= u)
                    pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_tag[i] = model_tag[i-1];
                    model_urg[i] = model_urg[i-1];
                end
                model_tag[pos] = r.entry_tag;
                model_urg[pos] = u;
                model_count++;
            end
        end
        else begin
            if (model_count == 0) begin
                o.empty_serve = 1'b1;
            end
            else begin
                o.served_valid   = 1'b1;
                o.served_tag     = model_tag[0];
                o.served_urgency = model_urg[0];
                for (int i = 1; i < model_count; i++) begin
                    model_tag[i-1] = model_tag[i];
                    model_urg[i-1] = model_urg[i];
                end
                model_count--;
            end
        end
        if (model_count > 0) begin
            o.head_valid   = 1'b1;
            o.head_tag     = model_tag[0];
            o.head_urgency = model_urg[0];
        end
        o.occupancy = model_count[OCC_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: mismatch %s got %h expected %h", $time, what, got, want);
        end
    endtask

    // monitor, predictor hookup and watchdog
    always @(posedge clk) begin
        rsp_t want;
        bit   moved;
        moved = 1'b0;
        if (rst_n) begin
            if (done === 1'b1) begin
                moved = 1'b1;
                if (rsp_due.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result with no request outstanding", $time);
                end
                else begin
                    want = rsp_due.pop_front();
                    report_mismatch("served_valid", 16'(rsp.served_valid),
                                    16'(want.served_valid));
                    report_mismatch("served_tag", rsp.served_tag, want.served_tag);
                    report_mismatch("served_urgency", 16'(rsp.served_urgency),
                                    16'(want.served_urgency));
                    report_mismatch("empty_serve", 16'(rsp.empty_serve),
                                    16'(want.empty_serve));
                    report_mismatch("insert_dropped", 16'(rsp.insert_dropped),
                                    16'(want.insert_dropped));
                    report_mismatch("head_valid", 16'(rsp.head_valid),
                                    16'(want.head_valid));
                    report_mismatch("head_tag", rsp.head_tag, want.head_tag);
                    report_mismatch("head_urgency", 16'(rsp.head_urgency),
                                    16'(want.head_urgency));
                    report_mismatch("occupancy", 16'(rsp.occupancy),
                                    16'(want.occupancy));
                end
            end
            if (start && busy === 1'b0) begin
                moved = 1'b1;
                rsp_due.push_back(queue_model_step(req));
                void'(req_backlog.pop_front());
                n_taken++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge clk) begin
        bit idle;
        idle = ($urandom_range(0, 99) < IDLE_PCT)
               && !(n_taken >= QUIET_FROM && n_taken < QUIET_TO);
        if (!rst_n || req_backlog.size() == 0 || idle
            || (req_backlog[0].drain && rsp_due.size() != 0)) begin
            start <= 1'b0;
        end
        else begin
            start <= 1'b1;
            req   <= req_backlog[0].r;
        end
    end

    function automatic req_t make_req(logic kind, logic [OUT_TAG_W-1:0] tag, logic [URG_W-1:0] u);
        req_t r;
        r.req_type  = kind;
        r.entry_tag = tag;
        r.urgency   = u;
        return r;
    endfunction

    function automatic req_t random_req(bit serve);
        logic [URG_W-1:0] u;
        if (serve)
            u = 3'($urandom_range(0, 7));
        else if ($urandom_range(0, 99) < 85)
            u = 3'($urandom_range(1, 5));
        else
            u = $urandom_range(0, 2) == 0 ? 3'd0 : 3'($urandom_range(6, 7));
        return make_req(serve ? REQ_SERVE : REQ_INSERT, 16'($urandom_range(0, 65535)), u);
    endfunction

    initial begin
        backlog_item_t it;
        int            made;
        int            run_len;
        int            ins_pct;
        int            pct_list[6];

        pct_list = '{10, 35, 50, 65, 90, 100};
        it.drain = 1'b0;

        it.r = make_req(REQ_SERVE, 16'hFFFF, 3'd7);  req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'hFFFF, 3'd3); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h0000, 3'd3); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h1234, 3'd0); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'hABCD, 3'd7); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h5555, 3'd6); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'hAAAA, 3'd5); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h0001, 3'd1); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h8000, 3'd2); req_backlog.push_back(it);
        it.r = make_req(REQ_INSERT, 16'h7FFF, 3'd4); req_backlog.push_back(it);
        for (int i = 0; i < 10; i++) begin
            it.r = make_req(REQ_SERVE, 16'(i * 16'h1111), 3'(i));
            req_backlog.push_back(it);
        end
        it.r = make_req(REQ_INSERT, 16'h00FF, 3'd1); req_backlog.push_back(it);
        it.r = make_req(REQ_SERVE, 16'h0000, 3'd0);  req_backlog.push_back(it);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            ins_pct = pct_list[$urandom_range(0, 5)];
            run_len = $urandom_range(10, 40);
            for (int i = 0; i < run_len; i++) begin
                it.r     = random_req($urandom_range(0, 99) >= ins_pct);
                it.drain = (made == 0) || ($urandom_range(0, 49) == 0);
                req_backlog.push_back(it);
                made++;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rsp_due.size() != 0) begin
            mismatch_cnt++;
            $display("%0d results never arrived", rsp_due.size());
        end
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
